/* rtl/fkg_pkg.sv */
`timescale 1ns / 1ps
package fkg_pkg;
    localparam int MaxItems = 16;
    localparam int IdxW = $clog2(MaxItems);
    localparam int CntW = $clog2(MaxItems + 1);
    localparam int ProfitW = 28;
    localparam int WholeW = 5;
    localparam int QDepth = 2;
    localparam logic [ProfitW-1:0] ProfitMax = '1;

    // one loaded item, handed from the front to the back
    typedef struct packed {
        logic [15:0] weight;
        logic [15:0] value;
        logic        last;
        logic        keep;
        logic        dropped;
    } t_req;

    // status lines between queue and back
    typedef struct packed {
        logic valid;
        logic pop;
    } t_qctl;
endpackage

/* rtl/fkg_ram.sv */
`timescale 1ns / 1ps
module fkg_ram #(
    parameter int Width = 16,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/fkg_front.sv */
`timescale 1ns / 1ps
module fkg_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_accept,
    input  logic [15:0]    i_item_weight,
    input  logic [15:0]    i_item_value,
    input  logic           i_last_item,
    output fkg_pkg::t_req  o_req
);
    import fkg_pkg::*;
    logic [CntW-1:0] r_count;
    logic            r_ovf;
    logic            w_keep;

    assign w_keep = r_count < CntW'(MaxItems);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_accept) begin
            if (i_last_item) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (w_keep) begin
                r_count <= r_count + 1'b1;
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_comb begin
        o_req.weight  = i_item_weight;
        o_req.value   = i_item_value;
        o_req.last    = i_last_item;
        o_req.keep    = w_keep;
        o_req.dropped = r_ovf | ~w_keep;
    end

    logic w_unused;
    assign w_unused = i_start;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MaxItems)) else $error("count past capacity");
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_count == CntW'(MaxItems)) else $error("overflow early");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last_item) |=> r_count == '0) else $error("no clear");
`endif
endmodule

/* rtl/fkg_back.sv */
`timescale 1ns / 1ps
module fkg_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [15:0]                  i_capacity,
    input  fkg_pkg::t_qctl               i_qctl,
    input  fkg_pkg::t_req                i_req,
    output logic                         o_pop,
    output logic                         o_idle,
    output logic                         o_valid,
    output logic [fkg_pkg::ProfitW-1:0]  o_total_profit,
    output logic [fkg_pkg::WholeW-1:0]   o_whole_items_taken,
    output logic                         o_fraction_taken,
    output logic                         o_items_dropped
);
    import fkg_pkg::*;

    typedef enum logic [7:0] {
        S_LOAD  = 8'b0000_0001,
        S_RD    = 8'b0000_0010,
        S_CMP   = 8'b0000_0100,
        S_SWAP  = 8'b0000_1000,
        S_FRD   = 8'b0001_0000,
        S_FILL  = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [CntW-1:0]  r_n;
    logic [IdxW-1:0]  r_j;
    logic [CntW-1:0]  r_lim;
    logic [CntW-1:0]  r_i;
    logic             r_drop;
    logic             r_phase;
    logic [15:0]      r_wa, r_va, r_wb, r_vb;
    logic [31:0]      r_pa, r_pb;
    logic [16:0]      r_rem;
    logic [ProfitW+8:0] r_prof;
    logic [WholeW-1:0] r_whole;
    logic             r_frac;
    logic [39:0]      r_num;
    logic [16:0]      r_part;
    logic [5:0]       r_bit;
    logic [23:0]      r_quo;
    logic [31:0]      r_mul;

    logic             w_we;
    logic [IdxW-1:0]  w_waddr, w_raddr;
    logic [31:0]      w_wdata, w_rdata;

    fkg_ram #(.Width(32), .Depth(MaxItems)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    assign o_pop  = r_state == S_LOAD && i_qctl.valid;
    assign o_idle = r_state == S_LOAD && !i_qctl.valid;

    logic [16:0] w_sub;
    assign w_sub = {r_part[15:0], r_num[39]} - {1'b0, r_wa};

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_n[IdxW-1:0];
        w_wdata = {i_req.weight, i_req.value};
        w_raddr = r_j;
        if (r_state == S_LOAD) begin
            w_we = o_pop && i_req.keep;
        end else if (r_state == S_SWAP) begin
            // write back the pair in swapped order, one word a cycle
            w_we    = r_pa < r_pb;
            w_waddr = r_phase ? r_j + 1'b1 : r_j;
            w_wdata = r_phase ? {r_wa, r_va} : {r_wb, r_vb};
        end else if (r_state == S_RD) begin
            w_raddr = r_phase ? r_j + 1'b1 : r_j;
        end else if (r_state == S_FRD) begin
            w_raddr = r_i[IdxW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_n     <= '0;
            o_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (o_pop) begin
                        if (i_req.keep) r_n <= r_n + 1'b1;
                        if (i_req.last) begin
                            r_drop  <= i_req.dropped;
                            r_j     <= '0;
                            r_phase <= 1'b0;
                            r_lim   <= (i_req.keep ? r_n + 1'b1 : r_n) - 1'b1;
                            r_i     <= '0;
                            r_rem   <= {1'b0, i_capacity};
                            r_prof  <= '0;
                            r_whole <= '0;
                            r_frac  <= 1'b0;
                            if ((i_req.keep ? r_n + 1'b1 : r_n) > CntW'(1))
                                r_state <= S_RD;
                            else
                                r_state <= S_FRD;
                        end
                    end
                end
                S_RD: begin
                    // two reads, data lands in the cycle after each read
                    r_phase <= ~r_phase;
                    if (r_phase) begin
                        {r_wa, r_va} <= w_rdata;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (r_phase) begin
                        r_pa <= 32'(r_va) * 32'(r_wb);
                        r_pb <= 32'(r_vb) * 32'(r_wa);
                        r_phase <= 1'b0;
                        r_state <= S_SWAP;
                    end else begin
                        {r_wb, r_vb} <= w_rdata;
                        r_phase <= 1'b1;
                    end
                end
                S_SWAP: begin
                    if (r_pa >= r_pb || r_phase) begin
                        r_phase <= 1'b0;
                        if (CntW'(r_j) + 1'b1 >= r_lim) begin
                            r_j   <= '0;
                            r_lim <= r_lim - 1'b1;
                            r_state <= (r_lim > CntW'(1)) ? S_RD : S_FRD;
                        end else begin
                            r_j <= r_j + 1'b1;
                            r_state <= S_RD;
                        end
                    end else begin
                        r_phase <= 1'b1;
                    end
                end
                S_FRD: begin
                    if (r_i >= r_n) begin
                        r_state <= S_DONE;
                    end else begin
                        r_phase <= ~r_phase;
                        if (r_phase) r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    r_wa <= w_rdata[31:16];
                    if (r_rem >= {1'b0, w_rdata[31:16]}) begin
                        r_rem   <= r_rem - {1'b0, w_rdata[31:16]};
                        r_prof  <= r_prof + {13'd0, w_rdata[15:0], 8'd0};
                        r_whole <= r_whole + 1'b1;
                        r_i     <= r_i + 1'b1;
                        r_state <= S_FRD;
                    end else if (r_rem == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_mul   <= 32'(w_rdata[15:0]) * 32'(r_rem[15:0]);
                        r_bit   <= 6'd41;
                        r_part  <= '0;
                        r_frac  <= 1'b1;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // restoring division, one quotient bit a cycle
                    if (r_bit == 6'd41) begin
                        r_num <= {r_mul, 8'd0};
                        r_quo <= '0;
                        r_bit <= 6'd40;
                    end else if (r_bit == '0) begin
                        r_prof  <= r_prof + {13'd0, r_quo};
                        r_state <= S_DONE;
                    end else begin
                        if (!w_sub[16]) begin
                            r_part <= w_sub;
                            r_quo  <= {r_quo[22:0], 1'b1};
                        end else begin
                            r_part <= {r_part[15:0], r_num[39]};
                            r_quo  <= {r_quo[22:0], 1'b0};
                        end
                        r_num <= {r_num[38:0], 1'b0};
                        r_bit <= r_bit - 1'b1;
                    end
                end
                S_DONE: begin
                    o_valid <= 1'b1;
                    o_total_profit <= (r_prof > {9'd0, ProfitMax}) ? ProfitMax
                                      : r_prof[ProfitW-1:0];
                    o_whole_items_taken <= r_whole;
                    o_fraction_taken    <= r_frac;
                    o_items_dropped     <= r_drop;
                    r_n     <= '0;
                    r_state <= S_LOAD;
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    logic w_unused;
    assign w_unused = i_qctl.pop;

`ifndef NO_ASSERTIONS
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result held");
    a_pop_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == S_LOAD) else $error("pop outside load");
`endif
endmodule

/* rtl/fkg_queue.sv */
`timescale 1ns / 1ps
module fkg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fkg_pkg::t_req  i_req,
    input  logic           i_pop,
    output fkg_pkg::t_qctl o_qctl,
    output fkg_pkg::t_req  o_req,
    output logic           o_full
);
    import fkg_pkg::*;
    t_req r_q [QDepth];
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_pop) begin
            // advance the head; a request arriving into a single-entry queue lands at the head
            r_q[0] <= (i_push && r_cnt == 2'd1) ? i_req : r_q[1];
            if (i_push && r_cnt == 2'd2) r_q[1] <= i_req;
        end else if (i_push) begin
            r_q[r_cnt[0]] <= i_req;
        end
    end

    assign o_qctl.valid = r_cnt != '0;
    assign o_qctl.pop   = i_pop;
    assign o_req  = r_q[0];
    assign o_full = r_cnt == 2'(QDepth);

`ifndef NO_ASSERTIONS
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop)) else $error("queue overrun");
    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != '0) else $error("queue underrun");
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QDepth)) else $error("count past depth");
`endif
endmodule

/* rtl/fractional_knapsack_greedy.sv */
`timescale 1ns / 1ps
// Items are loaded one per cycle while busy is low; a two-entry queue lets
// the loader run ahead of the sorter. On the last item the sorter runs a
// bubble sort through a RAM with one read and one write port, then the
// greedy fill runs over the sorted items and a bit-serial divider works
// out the fractional part. The result appears for one cycle with o_done
// high and cannot be stalled; busy stays high from the last item until the
// result is out.
module fractional_knapsack_greedy (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        busy,
    input  logic [15:0] i_item_weight,
    input  logic [15:0] i_item_value,
    input  logic        i_last_item,
    output logic        o_done,
    output logic [27:0] o_total_profit,
    output logic [4:0]  o_whole_items_taken,
    output logic        o_fraction_taken,
    output logic        o_items_dropped,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fkg_pkg::*;
    logic [15:0] r_capacity;
    logic        r_busy;
    logic        w_accept, w_full, w_pop, w_idle;
    t_req        w_freq, w_qreq;
    t_qctl       w_qctl;

    assign pready = 1'b1;
    assign prdata = paddr ? 32'd0 : {16'd0, r_capacity};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_capacity <= '0;
        else if (psel && penable && pwrite && !paddr) r_capacity <= pwdata[15:0];
    end

    assign busy     = r_busy | w_full;
    assign w_accept = i_start && !busy;

    // hold busy from the last item until the result is shown
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_busy <= 1'b0;
        else if (w_accept && i_last_item) r_busy <= 1'b1;
        else if (o_done) r_busy <= 1'b0;
    end

    fkg_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_accept(w_accept),
        .i_item_weight(i_item_weight), .i_item_value(i_item_value),
        .i_last_item(i_last_item), .o_req(w_freq)
    );

    fkg_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_accept), .i_req(w_freq),
        .i_pop(w_pop), .o_qctl(w_qctl), .o_req(w_qreq), .o_full(w_full)
    );

    fkg_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_capacity(r_capacity),
        .i_qctl(w_qctl), .i_req(w_qreq), .o_pop(w_pop), .o_idle(w_idle),
        .o_valid(o_done), .o_total_profit(o_total_profit),
        .o_whole_items_taken(o_whole_items_taken),
        .o_fraction_taken(o_fraction_taken), .o_items_dropped(o_items_dropped)
    );

`ifndef NO_ASSERTIONS
    a_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last_item) |=> busy) else $error("busy dropped");
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_busy) else $error("result while idle");
    a_idle_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_idle && !r_busy) |-> !w_full) else $error("idle yet full");
`endif
endmodule

/* test/fractional_knapsack_greedy_tb.sv */
`timescale 1ns / 1ps
module fractional_knapsack_greedy_tb;
    import fkg_pkg::*;

    typedef struct {
        logic [ProfitW-1:0] profit;
        logic [WholeW-1:0]  whole;
        logic               frac;
        logic               dropped;
    } t_outcome;

    localparam logic CapAddr = 1'b0;

    class knapsack_board;
        logic [15:0] wts[$];
        logic [15:0] vals[$];
        logic        overflow;
        logic [15:0] cap;
        t_outcome    pending[$];
        int          errors;
        int          sets_done;

        function new();
            overflow = 1'b0;
            cap = '0;
            errors = 0;
            sets_done = 0;
        endfunction

        // rank by ratio (stable) and fill greedily
        function void note_request(logic [15:0] w, logic [15:0] v, logic last);
            logic [15:0] sw[$];
            logic [15:0] sv[$];
            logic [15:0] tw;
            logic [15:0] tv;
            logic [63:0] room;
            logic [63:0] gain;
            int          n;
            t_outcome    o;
            if (wts.size() < MaxItems) begin
                wts.push_back(w);
                vals.push_back(v);
            end else begin
                overflow = 1'b1;
            end
            if (!last) return;
            sw = wts;
            sv = vals;
            n = sw.size();
            for (int i = 0; i + 1 < n; i++) begin
                for (int j = 0; j + 1 < n - i; j++) begin
                    if (64'(sv[j]) * sw[j+1] < 64'(sv[j+1]) * sw[j]) begin
                        tw = sw[j]; sw[j] = sw[j+1]; sw[j+1] = tw;
                        tv = sv[j]; sv[j] = sv[j+1]; sv[j+1] = tv;
                    end
                end
            end
            room = cap;
            gain = 0;
            o.whole = '0;
            o.frac = 1'b0;
            for (int i = 0; i < n; i++) begin
                if (room >= sw[i]) begin
                    gain += 64'(sv[i]) << 8;
                    room -= sw[i];
                    o.whole++;
                end else begin
                    if (room > 0) begin
                        gain += ((64'(sv[i]) * room) << 8) / sw[i];
                        o.frac = 1'b1;
                    end
                    break;
                end
            end
            o.profit = (gain > 64'(ProfitMax)) ? ProfitMax : gain[ProfitW-1:0];
            o.dropped = overflow;
            pending.push_back(o);
            wts.delete();
            vals.delete();
            overflow = 1'b0;
        endfunction

        function void check_result(t_outcome got);
            t_outcome want;
            if (pending.size() == 0) begin
                report("result with nothing outstanding");
                return;
            end
            want = pending.pop_front();
            sets_done++;
            if (got.profit !== want.profit)
                report($sformatf("profit %0h want %0h", got.profit, want.profit));
            if (got.whole !== want.whole)
                report($sformatf("whole %0d want %0d", got.whole, want.whole));
            if (got.frac !== want.frac)
                report($sformatf("fraction %0b want %0b", got.frac, want.frac));
            if (got.dropped !== want.dropped)
                report($sformatf("dropped %0b want %0b", got.dropped, want.dropped));
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 30) $display("MISMATCH @%0t: %s", $realtime, msg);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        busy;
    logic [15:0] i_item_weight;
    logic [15:0] i_item_value;
    logic        i_last_item;
    logic        o_done;
    logic [27:0] o_total_profit;
    logic [4:0]  o_whole_items_taken;
    logic        o_fraction_taken;
    logic        o_items_dropped;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic        paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    knapsack_board board;
    int            requests;

    fractional_knapsack_greedy u_top (.*);

    always begin
        i_clk = 1'b0; #4;
        i_clk = 1'b1; #4;
    end

    always @(posedge i_clk) begin
        t_outcome got;
        if (i_rst_n && o_done) begin
            got.profit = o_total_profit;
            got.whole = o_whole_items_taken;
            got.frac = o_fraction_taken;
            got.dropped = o_items_dropped;
            board.check_result(got);
        end
    end

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        repeat (n) @(negedge i_clk);
    endtask

    task automatic send_request(logic [15:0] w, logic [15:0] v, logic last);
        i_start = 1'b1;
        i_item_weight = w;
        i_item_value = v;
        i_last_item = last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_request(w, v, last);
        requests++;
        @(negedge i_clk);
        i_start = 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_capacity(logic [15:0] c);
        drain();
        psel = 1'b1; pwrite = 1'b1; paddr = CapAddr; pwdata = 32'(c);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.cap = c;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic random_set(int n, bit gaps);
        for (int i = 0; i < n; i++) begin
            logic [15:0] w;
            logic [15:0] v;
            case ($urandom_range(0, 5))
                0: w = 16'($urandom_range(1, 65535));
                1: w = 16'hFFFF;
                default: w = 16'($urandom_range(1, 300));
            endcase
            v = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom);
            send_request(w, v, i == n - 1);
            if (gaps) idle_gap();
        end
    endtask

    initial begin
        #40_000_000;
        $display("fractional_knapsack_greedy verification failed");
        $finish;
    end

    initial begin
        logic [15:0] caps[$];
        board = new();
        requests = 0;
        i_rst_n = 1'b0; i_start = 1'b0;
        i_item_weight = 16'd1; i_item_value = '0; i_last_item = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = CapAddr; pwdata = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // capacity zero from reset: nothing fits
        send_request(16'd5, 16'd7, 1'b1);
        set_capacity(16'hFFFF);
        send_request(16'hFFFF, 16'hFFFF, 1'b0);
        send_request(16'd1, 16'd0, 1'b1);
        set_capacity(16'd10);
        // equal ratios keep arrival order; exact fit leaves no room
        send_request(16'd4, 16'd8, 1'b0);
        send_request(16'd2, 16'd4, 1'b0);
        send_request(16'd4, 16'd9, 1'b1);
        // fraction of the next item
        send_request(16'd3, 16'd100, 1'b0);
        send_request(16'd9, 16'd50, 1'b1);
        // set too large, last carried on a dropped request
        for (int i = 0; i < 18; i++)
            send_request(16'(i + 1), 16'(i * 3), i == 17);

        caps = '{16'd0, 16'd1, 16'd500, 16'd2000, 16'hFFFF, 16'($urandom)};
        while (requests < 620) begin
            if ($urandom_range(0, 7) == 0) set_capacity(caps[$urandom_range(0, 5)]);
            if ($urandom_range(0, 9) == 0) drain();
            random_set($urandom_range(0, 9) == 0 ? $urandom_range(17, 20)
                                                 : $urandom_range(1, 16),
                       $urandom_range(0, 2) != 0);
        end
        drain();

        $display("Covered %0d requests in %0d sets over several capacities,",
                 requests, board.sets_done);
        $display("including overfull sets, zero capacity and exact fits.");
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("fractional_knapsack_greedy verification clean");
        end else begin
            $display("fractional_knapsack_greedy verification failed");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/fkg_pkg.sv
rtl/fkg_ram.sv
rtl/fkg_front.sv
rtl/fkg_back.sv
rtl/fkg_queue.sv
rtl/fractional_knapsack_greedy.sv
test/fractional_knapsack_greedy_tb.sv
